FILE: hw/rtl/pbcd_pkg.sv
// Shared types, constants and digit helpers for the packed BCD converter.
package pbcd_pkg;

	localparam int BIN_W     = 32;
	localparam int BCD_W     = 40;
	localparam int BCD_BYTES = BCD_W / 8;
	localparam int NIB_W     = 4;
	localparam int DIGITS    = BCD_W / NIB_W;
	localparam int ENC_STEPS = BIN_W;
	localparam int DEC_STEPS = DIGITS;
	localparam int STEP_W    = $clog2(ENC_STEPS);
	localparam int CNT_W     = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_DEC,
		ST_DONE
	} pbcd_state_t;

	typedef struct packed {
		logic             func;
		logic [CNT_W-1:0] num_bytes;
		logic [BIN_W-1:0] binary_in;
		logic [BCD_W-1:0] bcd_in;
	} pbcd_req_t;

	typedef struct packed {
		logic [BCD_W-1:0] bcd_out;
		logic [BIN_W-1:0] binary_out;
	} pbcd_res_t;

	// Keep the lowest cnt bytes.
	function automatic logic [BCD_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
		logic [BCD_W-1:0] m;
		m = '0;
		for (int k = 0; k < BCD_BYTES; k++) begin
			if (k < int'(cnt)) begin
				m[8*k +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	// Double-dabble correction: add three to every digit of five or more.
	function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		r = v;
		for (int d = 0; d < DIGITS; d++) begin
			if (v[NIB_W*d +: NIB_W] >= 4'd5) begin
				r[NIB_W*d +: NIB_W] = v[NIB_W*d +: NIB_W] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/pbcd_serial.sv
// Bit-serial binary to BCD encoder and nibble-serial BCD to binary decoder.
module pbcd_serial #(
	parameter int MAX_BCD_BYTES = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pbcd_pkg::pbcd_req_t   req,
	output logic                  res_valid,
	input  logic                  res_ready,
	output pbcd_pkg::pbcd_res_t   res
);
	import pbcd_pkg::*;

	pbcd_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              func_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_eff;
	logic [BIN_W-1:0]  sh_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic              load;
	logic              step_en;

	// Saturate the byte count at the configured maximum.
	assign cnt_eff = (int'(req.num_bytes) > MAX_BCD_BYTES) ? CNT_W'(MAX_BCD_BYTES)
	                                                      : req.num_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (step_en) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		load      = 1'b0;
		step_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load    = 1'b1;
					state_d = req.func ? ST_DEC : ST_ENC;
				end
			end
			ST_ENC: begin
				step_en = 1'b1;
				if (step_q == STEP_W'(ENC_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DEC: begin
				step_en = 1'b1;
				if (step_q == STEP_W'(DEC_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign bcd_adj = add3(bcd_q);

	always_ff @(posedge clk) begin
		if (load) begin
			func_q <= req.func;
			cnt_q  <= cnt_eff;
			if (req.func) begin
				sh_q  <= '0;
				// Unused bytes become leading zeros and add nothing.
				bcd_q <= req.bcd_in & byte_mask(cnt_eff);
			end else begin
				sh_q  <= req.binary_in;
				bcd_q <= '0;
			end
		end else if (step_en) begin
			if (func_q) begin
				// acc = acc * 10 + next nibble, most significant first
				sh_q  <= (sh_q << 3) + (sh_q << 1)
				         + {{(BIN_W-NIB_W){1'b0}}, bcd_q[BCD_W-1 -: NIB_W]};
				bcd_q <= bcd_q << NIB_W;
			end else begin
				bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[BIN_W-1]};
				sh_q  <= sh_q << 1;
			end
		end
	end

	assign res.binary_out = func_q ? sh_q : '0;
	assign res.bcd_out    = func_q ? '0 : (bcd_q & byte_mask(cnt_q));

endmodule

FILE: hw/rtl/packed_bcd_binary_converter.sv
// Two-way binary / packed BCD converter: accepts one word, runs serially, returns one word.
// Binary to BCD runs shift-and-add-three, one binary bit per cycle.
// BCD to binary takes one nibble per cycle through a times-ten accumulator.
// From accept, a result passes the encode or decode state, the done state and the output
// register to m_axis_tvalid; a new word is taken only once the last has left the done state.
// arst_n clears the sequencer and the output valid; data registers are not reset.
module packed_bcd_binary_converter #(
	parameter int MAX_BCD_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // num_bytes[2:0], binary_in[34:3], bcd_in[74:35], zero
	input  logic [0:0]  s_axis_tuser,  // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // binary_out[31:0], bcd_out[71:32]
);
	import pbcd_pkg::*;

	pbcd_req_t req;
	pbcd_res_t res;
	pbcd_res_t m_res_q;
	logic      res_valid;
	logic      res_ready;
	logic      m_valid_q;

	assign req.func      = s_axis_tuser[0];
	assign req.num_bytes = s_axis_tdata[CNT_W-1:0];
	assign req.binary_in = s_axis_tdata[CNT_W +: BIN_W];
	assign req.bcd_in    = s_axis_tdata[CNT_W+BIN_W +: BCD_W];

	pbcd_serial #(
		.MAX_BCD_BYTES(MAX_BCD_BYTES)
	) u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register: take a new word when empty or being drained.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_res_q.bcd_out, m_res_q.binary_out};

endmodule
